/* hw/rtl/xdv_pkg.sv */
// ---------------------------------------------------------------------------
// xdv_pkg
// Shared constants and types of the XOR-delta varint encoder.
// ---------------------------------------------------------------------------
package xdv_pkg;

	// Width of each posting field; bits above it are ignored (range 8..64).
	localparam int VALUE_BITS = 64;

	// LEB128 group size
	localparam int GROUP_BITS = 7;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [1:0]            field_idx_t;

	localparam field_idx_t FIELD_ORD    = 2'd0;
	localparam field_idx_t FIELD_VALID  = 2'd1;
	localparam field_idx_t FIELD_COMMIT = 2'd2;

endpackage

/* hw/rtl/xor_delta_varint_encoder.sv */
// ---------------------------------------------------------------------------
// xor_delta_varint_encoder
// Turns postings into XOR-delta LEB128 byte streams, one byte per beat.
// ---------------------------------------------------------------------------
// Each input beat carries one posting (row_ordinal, valid_start, commit_number,
// start_of_set). Every field is XORed with the same field of the previous
// posting (zero after reset and when start_of_set is high) and sent out as
// an unsigned LEB128 varint: low 7-bit group first, bit 7 set while more
// bytes of that field follow. Fields leave in the order ordinal, valid-from,
// commit sequence; field_index tags each byte and last_of_item marks the
// final byte of the posting. A posting therefore costs 3 to 30 output beats
// (one per byte), and the block sustains exactly one output byte per cycle
// while out_stall is low: the byte emitter is the bottleneck, so postings
// are taken no faster than their bytes are emitted.
// Three register stages (input delta register, byte emitter, output
// register) lie between an input beat and its first output byte.
// The input register lets the next posting be taken while the current one
// is still being emitted. The output register holds a finished byte steady
// under out_stall; the emitter pauses while it waits and refills it in the
// cycle the byte is taken, so an unstalled stream has no bubbles. Both
// channels use valid/stall: a beat moves on a rising edge with valid high
// and stall low.
// ---------------------------------------------------------------------------
module xor_delta_varint_encoder
	import xdv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] row_ordinal,
	input  logic [63:0] valid_start,
	input  logic [63:0] commit_number,
	input  logic        start_of_set,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  field_index,
	output logic        last_of_item
);

	// previous posting, kept masked to VALUE_BITS
	value_t prior_ord_q, prior_vf_q, prior_cs_q;

	// stage 1: deltas of the accepted posting
	logic   valid_s1;
	value_t d_ord_s1, d_vf_s1, d_cs_s1;

	// stage 2: byte emitter; cur is the remainder of the field in flight
	logic       em_valid_s2;
	value_t     cur_s2, nxt1_s2, nxt2_s2;
	field_idx_t fld_s2;

	// stage 3: output register
	logic       out_valid_s3;
	logic [7:0] byte_s3;
	field_idx_t fld_s3;
	logic       last_s3;

	logic   in_accept, out_load, step, more, em_done, em_free, s1_take;
	value_t ord_m, vf_m, cs_m;

	assign ord_m = row_ordinal[VALUE_BITS-1:0];
	assign vf_m  = valid_start[VALUE_BITS-1:0];
	assign cs_m  = commit_number[VALUE_BITS-1:0];

	// current group is not the last one of its field
	assign more = |cur_s2[VALUE_BITS-1:GROUP_BITS];

	assign out_load = !out_valid_s3 || !out_stall;
	assign step     = em_valid_s2 && out_load;
	assign em_done  = step && !more && (fld_s2 == FIELD_COMMIT);
	assign em_free  = !em_valid_s2 || em_done;
	assign s1_take  = valid_s1 && em_free;

	assign in_stall  = valid_s1 && !em_free;
	assign in_accept = in_valid && !in_stall;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			em_valid_s2  <= 1'b0;
			out_valid_s3 <= 1'b0;
			prior_ord_q  <= '0;
			prior_vf_q   <= '0;
			prior_cs_q   <= '0;
		end else begin
			if (in_accept) begin
				valid_s1    <= 1'b1;
				prior_ord_q <= ord_m;
				prior_vf_q  <= vf_m;
				prior_cs_q  <= cs_m;
			end else if (s1_take) begin
				valid_s1 <= 1'b0;
			end

			if (s1_take) begin
				em_valid_s2 <= 1'b1;
			end else if (em_done) begin
				em_valid_s2 <= 1'b0;
			end

			if (step) begin
				out_valid_s3 <= 1'b1;
			end else if (out_load) begin
				out_valid_s3 <= 1'b0;
			end
		end
	end

	// delta register: start of set means priors read as zero
	always_ff @(posedge clk) begin
		if (in_accept) begin
			d_ord_s1 <= start_of_set ? ord_m : (ord_m ^ prior_ord_q);
			d_vf_s1  <= start_of_set ? vf_m  : (vf_m  ^ prior_vf_q);
			d_cs_s1  <= start_of_set ? cs_m  : (cs_m  ^ prior_cs_q);
		end
	end

	// emitter: shift out 7 bits per byte, then move to the next field
	always_ff @(posedge clk) begin
		if (s1_take) begin
			cur_s2  <= d_ord_s1;
			nxt1_s2 <= d_vf_s1;
			nxt2_s2 <= d_cs_s1;
			fld_s2  <= FIELD_ORD;
		end else if (step) begin
			if (more) begin
				cur_s2 <= cur_s2 >> GROUP_BITS;
			end else begin
				case (fld_s2)
					FIELD_ORD: begin
						cur_s2 <= nxt1_s2;
						fld_s2 <= FIELD_VALID;
					end
					FIELD_VALID: begin
						cur_s2 <= nxt2_s2;
						fld_s2 <= FIELD_COMMIT;
					end
					default: begin
						cur_s2 <= cur_s2;
					end
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (step) begin
			byte_s3 <= {more, cur_s2[GROUP_BITS-1:0]};
			fld_s3  <= fld_s2;
			last_s3 <= !more && (fld_s2 == FIELD_COMMIT);
		end
	end

	assign out_valid    = out_valid_s3;
	assign out_byte     = byte_s3;
	assign field_index  = fld_s3;
	assign last_of_item = last_s3;

endmodule

/* hw/rtl/xdv_checker.sv */
// ---------------------------------------------------------------------------
// xdv_checker
// Port-level checks on the output byte stream of the varint encoder.
// ---------------------------------------------------------------------------
module xdv_checker
	import xdv_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic [1:0] field_index,
	input logic       last_of_item
);

	// a held beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
			&& $stable(field_index) && $stable(last_of_item))
		else $error("output beat changed while stalled");

	// the posting ends on the last byte of the commit field
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_item |-> field_index == FIELD_COMMIT && !out_byte[7])
		else $error("last_of_item on a byte that is not the final commit byte");

	// final commit byte must close the posting
	a_commit_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_index == FIELD_COMMIT && !out_byte[7] |-> last_of_item)
		else $error("final commit byte without last_of_item");

	// a continued field goes on with the same field
	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_byte[7]
			|=> !out_valid || field_index == $past(field_index))
		else $error("field changed after a continuation byte");

endmodule

bind xor_delta_varint_encoder xdv_checker u_xdv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.out_byte     (out_byte),
	.field_index  (field_index),
	.last_of_item (last_of_item)
);

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the XOR-delta LEB128 varint encoder.
// ---------------------------------------------------------------------------
// Postings queued by the stimulus block are offered by a clocked driver. Each
// accepted posting is encoded by a local model into the byte beats it must
// produce. A clocked monitor compares every output beat, field by field, with
// the oldest expected beat. Both sides idle at random. One long receiver
// hold-off fills the block so that it must stall its input.
// ---------------------------------------------------------------------------
module tb_top
	import xdv_pkg::*;
();

	localparam int IDLE_PCT    = 13;
	localparam int RAND_ITEMS  = 450;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 20;
	// stretch where neither side idles
	localparam int CALM_FROM   = 2000;
	localparam int CALM_TO     = 3500;
	// long receiver hold-off
	localparam int HOLD_AT     = 600;
	localparam int HOLD_LEN    = 300;

	typedef struct packed {
		logic [63:0] ord;
		logic [63:0] vf;
		logic [63:0] cs;
		logic        sos;
	} posting_t;

	typedef struct packed {
		logic [7:0] data;
		field_idx_t fidx;
		logic       last;
	} byte_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] row_ordinal = '0;
	logic [63:0] valid_start = '0;
	logic [63:0] commit_number = '0;
	logic        start_of_set = 1'b0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic [1:0]  field_index;
	logic        last_of_item;

	posting_t    pending_postings[$];
	byte_beat_t  expected_bytes[$];

	// model state: fields of the previous accepted posting
	value_t      prior_ord = '0;
	value_t      prior_vf = '0;
	value_t      prior_cs = '0;

	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          hold_left = 0;

	xor_delta_varint_encoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.row_ordinal   (row_ordinal),
		.valid_start   (valid_start),
		.commit_number (commit_number),
		.start_of_set  (start_of_set),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.field_index   (field_index),
		.last_of_item  (last_of_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Model: varint bytes of one field difference
	// ------------------------------------------------------------------
	task automatic push_varint(input value_t diff, input field_idx_t fidx,
			input logic final_field);
		byte_beat_t beat;
		logic       more;
		value_t     rest;
		rest = diff;
		do begin
			more = (rest >= value_t'(8'h80));
			beat.data = {more, rest[6:0]};
			beat.fidx = fidx;
			beat.last = final_field && !more;
			expected_bytes.insert(expected_bytes.size(), beat);
			rest = rest >> GROUP_BITS;
		end while (more);
	endtask

	// Model: all beats of one accepted posting, then update the priors
	task automatic encode_posting(input posting_t p);
		value_t vmask;
		value_t ord;
		value_t vf;
		value_t cs;
		vmask = '1;  // value_t is VALUE_BITS wide, so this masks upper bits
		ord = value_t'(p.ord) & vmask;
		vf  = value_t'(p.vf) & vmask;
		cs  = value_t'(p.cs) & vmask;
		if (p.sos) begin
			prior_ord = '0;
			prior_vf  = '0;
			prior_cs  = '0;
		end
		push_varint(ord ^ prior_ord, FIELD_ORD, 1'b0);
		push_varint(vf ^ prior_vf, FIELD_VALID, 1'b0);
		push_varint(cs ^ prior_cs, FIELD_COMMIT, 1'b1);
		prior_ord = ord;
		prior_vf  = vf;
		prior_cs  = cs;
	endtask

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic logic idle_draw();
		if (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
			return 1'b0;
		return ($urandom_range(99, 0) < IDLE_PCT);
	endfunction

	// ------------------------------------------------------------------
	// Cycle counter and run limit
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected",
				cycle_count, expected_bytes.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver hold-off, counted on its own; the sender keeps offering
	always @(posedge clk) begin
		if (cycle_count == HOLD_AT)
			hold_left <= HOLD_LEN;
		else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// ------------------------------------------------------------------
	// Driver: offers the head of pending_postings; a stalled beat is held
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		logic     accepted;
		logic     offer;
		posting_t nxt;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			row_ordinal   <= '0;
			valid_start   <= '0;
			commit_number <= '0;
			start_of_set  <= 1'b0;
		end else begin
			accepted = in_valid && !in_stall;
			if (accepted) begin
				encode_posting(pending_postings.pop_front());
			end
			if (in_valid && !accepted) begin
				// stalled: payload and valid stay as they are
			end else begin
				offer = (pending_postings.size() != 0) && !idle_draw();
				in_valid <= offer;
				if (offer) begin
					nxt = pending_postings[0];
					row_ordinal   <= nxt.ord;
					valid_start   <= nxt.vf;
					commit_number <= nxt.cs;
					start_of_set  <= nxt.sos;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each accepted output beat, then draws the next stall
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		byte_beat_t exp_beat;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected beat byte=%02h field=%0d last=%0b",
						out_byte, field_index, last_of_item));
				end else begin
					exp_beat = expected_bytes.pop_front();
					if (out_byte !== exp_beat.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, exp_beat.data));
					if (field_index !== exp_beat.fidx)
						report_mismatch($sformatf("field_index %0d, expected %0d",
							field_index, exp_beat.fidx));
					if (last_of_item !== exp_beat.last)
						report_mismatch($sformatf("last_of_item %0b, expected %0b",
							last_of_item, exp_beat.last));
				end
			end
			out_stall <= (hold_left > 1) || idle_draw();
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	task automatic add_posting(input logic [63:0] ord, input logic [63:0] vf,
			input logic [63:0] cs, input logic sos);
		posting_t p;
		p.ord = ord;
		p.vf  = vf;
		p.cs  = cs;
		p.sos = sos;
		pending_postings.insert(pending_postings.size(), p);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// next value of one field, seen from its previous value
	function automatic logic [63:0] next_field(input logic [63:0] prev,
			input int kind);
		int k;
		case (kind)
			0: begin
				// small delta: a few low bits flipped
				k = $urandom_range(20, 1);
				return prev ^ (rand64() & ((64'd1 << k) - 64'd1));
			end
			1: return rand64();
			2: return prev;
			3: begin
				// delta sitting on a 7-bit group boundary
				k = 7 * $urandom_range(9, 1);
				if ($urandom_range(1, 0))
					return prev ^ (64'd1 << k);
				return prev ^ ((64'd1 << k) - 64'd1);
			end
			default: return prev ^ (rand64() >> $urandom_range(63, 0));
		endcase
	endfunction

	initial begin
		logic [63:0] g_ord;
		logic [63:0] g_vf;
		logic [63:0] g_cs;
		logic        g_sos;
		int          pick;
		int          kind;

		// directed: all-zero posting right after reset gives 00 00 00
		add_posting(64'd0, 64'd0, 64'd0, 1'b0);
		// all ones: ten bytes per field, longest posting
		add_posting('1, '1, '1, 1'b0);
		// same posting again: zero difference in every field
		add_posting('1, '1, '1, 1'b0);
		// start of set: priors cleared, full values go out again
		add_posting('1, '1, '1, 1'b1);
		// group edges: 0x7f is one byte, 0x80 two, 0x3fff two, 0x4000 three
		add_posting(64'h7f, 64'h80, 64'h3fff, 1'b1);
		add_posting(64'h7f ^ 64'h4000, 64'h80, 64'h3fff ^ 64'h7f, 1'b0);
		// top bit alone
		add_posting(64'h8000_0000_0000_0000, 64'd0, 64'h8000_0000_0000_0000, 1'b1);
		// alternating patterns, every bit toggles
		add_posting(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
			64'h5555_5555_5555_5555, 1'b0);
		add_posting(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
			64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		// start of set twice in a row with the same values
		add_posting(64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321, 64'd1, 1'b1);
		add_posting(64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321, 64'd1, 1'b1);
		// one field changing at a time
		add_posting(64'h1234_5678_9abc_def1, 64'h0fed_cba9_8765_4321, 64'd1, 1'b0);
		add_posting(64'h1234_5678_9abc_def1, 64'h0fed_cba9_8765_4320, 64'd1, 1'b0);
		add_posting(64'h1234_5678_9abc_def1, 64'h0fed_cba9_8765_4320, 64'd2, 1'b0);
		// back to zero values: difference equals previous value
		add_posting(64'd0, 64'd0, 64'd0, 1'b0);

		// random: mostly small deltas as a real index would give
		g_ord = '0;
		g_vf  = '0;
		g_cs  = '0;
		repeat (RAND_ITEMS) begin
			pick  = $urandom_range(99, 0);
			g_sos = ($urandom_range(99, 0) < 8);
			if (pick < 40)
				kind = 0;
			else if (pick < 55)
				kind = 1;
			else if (pick < 63)
				kind = 2;
			else if (pick < 75)
				kind = 3;
			else
				kind = -1;  // each field picks its own kind
			g_ord = next_field(g_ord, (kind < 0) ? $urandom_range(4, 0) : kind);
			g_vf  = next_field(g_vf, (kind < 0) ? $urandom_range(4, 0) : kind);
			g_cs  = next_field(g_cs, (kind < 0) ? $urandom_range(4, 0) : kind);
			add_posting(g_ord, g_vf, g_cs, g_sos);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// all postings accepted, then all bytes out, then a quiet tail
		while (pending_postings.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0 && expected_bytes.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
